### hw/rtl/rbd_pkg.sv
// Shared types and constants for the retry backoff decider.
// Holds the transfer payload structs, register indexes, reset policy and divider sizing.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

  // Field widths.
  localparam int ATTEMPT_BITS  = 16;
  localparam int MAX_ATT_BITS  = 16;
  localparam int DELAY_BITS    = 32;
  localparam int GROWTH_BITS   = 10;
  localparam int STATUS_BITS   = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 2;

  // Width used when comparing the attempt count against the attempt limit.
  localparam int CMP_BITS = (ATTEMPT_BITS > MAX_ATT_BITS) ? ATTEMPT_BITS : MAX_ATT_BITS;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ATTEMPTS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_DELAY = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DELAY     = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GROWTH        = 2'd3;

  // Status codes up to and including I/O error are retryable.
  localparam logic [STATUS_BITS-1:0] STATUS_LAST_RETRYABLE = 3'd3;

  // Default policy loaded at reset.
  localparam logic [MAX_ATT_BITS-1:0] DEF_MAX_ATTEMPTS  = 16'd5;
  localparam logic [DELAY_BITS-1:0]   DEF_INITIAL_DELAY = 32'd100;
  localparam logic [DELAY_BITS-1:0]   DEF_MAX_DELAY     = 32'd5000;
  localparam logic [GROWTH_BITS-1:0]  DEF_GROWTH        = 10'd200;

  // Divider sizing: the product is divided by the percent base one hex digit per cycle.
  localparam int PERCENT_BASE = 100;
  localparam int PROD_BITS    = DELAY_BITS + GROWTH_BITS;
  localparam int DIGIT_BITS   = 4;
  localparam int DIV_STEPS    = (PROD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int NUM_BITS     = DIV_STEPS * DIGIT_BITS;
  localparam int STEP_BITS    = $clog2(DIV_STEPS);
  localparam int REM_BITS     = $clog2(PERCENT_BASE);
  localparam int PART_BITS    = REM_BITS + DIGIT_BITS;
  // The largest product over the percent base stays below 2^36.
  localparam int QUO_BITS     = 36;

  typedef struct packed {
    logic [ATTEMPT_BITS-1:0] attempts_done;
    logic [STATUS_BITS-1:0]  status_kind;
  } in_item_t;

  typedef struct packed {
    logic                  retry_allowed;
    logic [DELAY_BITS-1:0] wait_ms;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [PROD_BITS-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [QUO_BITS-1:0] quotient;
  } div_res_t;

endpackage

`default_nettype wire

### hw/rtl/rbd_div100.sv
// Iterative divider by the percent base, one hex quotient digit per cycle.
// Depends on rbd_pkg for widths and the request and result structs.
`timescale 1ns / 1ps
`default_nettype none

module rbd_div100
  import rbd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_res_t      res
);

  localparam int DIGIT_MAX = (1 << DIGIT_BITS) - 1;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic [NUM_BITS-1:0]  num_r, num_nxt;
  logic [QUO_BITS-1:0]  quo_r, quo_nxt;
  logic [REM_BITS-1:0]  rem_r, rem_nxt;

  logic [PART_BITS-1:0]  part;
  logic [DIGIT_MAX-1:0]  ge;
  logic [DIGIT_BITS-1:0] digit;
  logic [PART_BITS-1:0]  part_sub;

  // Partial remainder with the next digit of the dividend shifted in; it stays
  // below sixteen times the base, so the digit is found by parallel compares.
  always_comb begin
    part = {rem_r, num_r[NUM_BITS-1 -: DIGIT_BITS]};
    for (int k = 1; k <= DIGIT_MAX; k++) begin
      ge[k-1] = part >= PART_BITS'(PERCENT_BASE * k);
    end
    digit    = DIGIT_BITS'($countones(ge));
    part_sub = PART_BITS'(digit) * PART_BITS'(PERCENT_BASE);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      num_nxt  = NUM_BITS'(req.dividend);
      quo_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt  = num_r << DIGIT_BITS;
      quo_nxt  = {quo_r[QUO_BITS-DIGIT_BITS-1:0], digit};
      rem_nxt  = REM_BITS'(part - part_sub);
      step_nxt = step_r + STEP_BITS'(1);
      if (step_r == STEP_BITS'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done     = done_r;
  assign res.quotient = quo_r;

endmodule

`default_nettype wire

### hw/rtl/retry_backoff_decider.sv
// Top level of the retry backoff decider: configuration registers, sequencer and multiplier.
// Depends on rbd_pkg and on the iterative divider rbd_div100.
//
// Usage: each transfer on the input channel carries the number of attempts
// already completed and the last failure status. For each input transfer the
// block returns exactly one result transfer holding the retry decision and the
// backoff delay in milliseconds. Retry is allowed when the attempt count is
// below max_attempts and the status is unavailable, timeout, busy or I/O error.
// The delay starts at initial_delay and grows once per completed attempt by
// growth_percent / 100 (floor), saturating at max_delay as soon as it reaches it.
//
// Sequencing: the block works on one request at a time and holds in_stall high
// from acceptance until the result has been loaded into the output register.
// Each growth step forms the 32 x 10 product and starts the shared divider,
// which produces the quotient one hex digit at a time; the sequencer then
// sees completion and either takes the next step or finishes. A request takes
// k growth steps, where k is the attempt count, cut short when the delay
// saturates or stops changing.
//
// Reset restores the default policy (5 attempts, 100 ms, 5000 ms, 200 percent)
// and empties the pipeline. When the receiver stalls, the result is held in the
// output register; a finished computation waits in the done state until the register is free,
// and a new input transfer can be taken while a result still waits to be taken.
// Configuration writes are meant to happen only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module retry_backoff_decider
  import rbd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Configuration write port.
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  // Input channel.
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire in_item_t                 in_data,
  // Result channel.
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output out_item_t                     out_data
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOP  = 2'd1;
  localparam logic [1:0] ST_DWAIT = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // Configuration registers.
  logic [MAX_ATT_BITS-1:0] max_attempts_r;
  logic [DELAY_BITS-1:0]   initial_delay_r;
  logic [DELAY_BITS-1:0]   max_delay_r;
  logic [GROWTH_BITS-1:0]  growth_r;

  // Sequencer state and working registers.
  logic [1:0]              state_r, state_nxt;
  logic [ATTEMPT_BITS-1:0] cnt_r, cnt_nxt;
  logic [ATTEMPT_BITS-1:0] iter_r, iter_nxt;
  logic [DELAY_BITS-1:0]   cur_r, cur_nxt;
  logic                    allow_r, allow_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  div_req_t div_req;
  div_res_t div_res;

  logic in_take;
  logic q_capped;
  logic q_same;

  // The shared divider turns each product into the next delay value.
  rbd_div100 u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Compare the divider's quotient against the ceiling and against the
  // current delay; an unchanged value means growth has reached a fixed point.
  assign q_capped = div_res.quotient >= QUO_BITS'(max_delay_r);
  assign q_same   = div_res.quotient == QUO_BITS'(cur_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    iter_nxt      = iter_r;
    cur_nxt       = cur_r;
    allow_nxt     = allow_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // The multiplier feeds the divider's dividend register directly.
    div_req.start    = 1'b0;
    div_req.dividend = PROD_BITS'(cur_r) * PROD_BITS'(growth_r);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          cnt_nxt   = in_data.attempts_done;
          iter_nxt  = '0;
          cur_nxt   = initial_delay_r;
          allow_nxt = (CMP_BITS'(in_data.attempts_done) < CMP_BITS'(max_attempts_r)) &&
                      (in_data.status_kind <= STATUS_LAST_RETRYABLE);
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (iter_r == cnt_r) begin
          state_nxt = ST_DONE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DWAIT;
        end
      end
      ST_DWAIT: begin
        if (div_res.done) begin
          if (q_capped) begin
            cur_nxt   = max_delay_r;
            state_nxt = ST_DONE;
          end else if (q_same) begin
            state_nxt = ST_DONE;
          end else begin
            // Below the ceiling, so the quotient fits the delay width.
            cur_nxt   = div_res.quotient[DELAY_BITS-1:0];
            iter_nxt  = iter_r + ATTEMPT_BITS'(1);
            state_nxt = ST_LOOP;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.retry_allowed = allow_r;
          out_data_nxt.wait_ms       = cur_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    iter_r     <= iter_nxt;
    cur_r      <= cur_nxt;
    allow_r    <= allow_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration registers come out of reset holding the default policy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_attempts_r  <= DEF_MAX_ATTEMPTS;
      initial_delay_r <= DEF_INITIAL_DELAY;
      max_delay_r     <= DEF_MAX_DELAY;
      growth_r        <= DEF_GROWTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_ATTEMPTS:  max_attempts_r  <= cfg_wdata[MAX_ATT_BITS-1:0];
        REG_INITIAL_DELAY: initial_delay_r <= cfg_wdata[DELAY_BITS-1:0];
        REG_MAX_DELAY:     max_delay_r     <= cfg_wdata[DELAY_BITS-1:0];
        REG_GROWTH:        growth_r        <= cfg_wdata[GROWTH_BITS-1:0];
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The divider only reports completion while the sequencer waits for it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == ST_DWAIT)
    else $error("divider completed outside the wait state");

  // The growth step count never passes the request's attempt count.
  a_iter_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOP || state_r == ST_DWAIT) |-> iter_r <= cnt_r)
    else $error("growth step count exceeded attempt count");

  // After at least one growth step the working delay lies below the ceiling.
  a_cur_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOP && iter_r != '0) |-> cur_r < max_delay_r)
    else $error("working delay reached the ceiling without saturating");

  // A new result only appears when the sequencer hands it over.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result appeared without a finished computation");

endmodule

`default_nettype wire
